>>> rtl/prat_pkg.sv
// ----------------------------------------------------------------------------
// prat_pkg
// Shared types, constants and helpers of the prefix rule address translator.
// ----------------------------------------------------------------------------
package prat_pkg;

	localparam int unsigned ADDR_W        = 32;
	localparam int unsigned SLOT_W        = 6;
	localparam int unsigned LEN_W         = 6;
	localparam int unsigned CFG_W         = 7;
	localparam int unsigned HIT_W         = 6;
	localparam int unsigned MAX_RULES_DEF = 64;
	localparam int unsigned GRP_SIZE      = 8;
	localparam int unsigned GRP_IW        = 3;

	typedef enum logic {
		OP_TRANSLATE = 1'b0,
		OP_WRITE     = 1'b1
	} opcode_t;

	// Input item, fields in interface order
	typedef struct packed {
		opcode_t             opcode;
		logic [ADDR_W-1:0]   requester_addr;
		logic [ADDR_W-1:0]   peer_addr;
		logic [SLOT_W-1:0]   rule_slot;
		logic [ADDR_W-1:0]   new_for_prefix;
		logic [LEN_W-1:0]    new_for_len;
		logic                new_stop;
		logic [ADDR_W-1:0]   new_from_prefix;
		logic [LEN_W-1:0]    new_from_len;
		logic [ADDR_W-1:0]   new_to_addr;
	} req_t;

	// Result item
	typedef struct packed {
		logic [ADDR_W-1:0]   result_addr;
		logic                rewritten;
		logic                stopped;
		logic                hit_valid;
		logic [HIT_W-1:0]    hit_rule;
	} rsp_t;

	// One stored rule; lengths are kept as bit masks
	typedef struct packed {
		logic [ADDR_W-1:0]   for_prefix;
		logic [ADDR_W-1:0]   for_mask;
		logic                stop;
		logic [ADDR_W-1:0]   from_prefix;
		logic [ADDR_W-1:0]   from_mask;
		logic [ADDR_W-1:0]   to_addr;
	} rule_t;

	// Rule write broadcast to every table cell
	typedef struct packed {
		logic                en;
		logic [SLOT_W-1:0]   slot;
		rule_t               rule;
	} rule_wr_t;

	// First firing rule within one group of cells
	typedef struct packed {
		logic                hit;
		logic [GRP_IW-1:0]   idx;
		logic                stop;
		logic [ADDR_W-1:0]   to_addr;
	} grp_t;

	// Mask of the len most significant bits; len above ADDR_W gives all ones
	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		for (int b = 0; b < ADDR_W; b++) begin
			m[b] = (LEN_W'(ADDR_W - 1 - b) < len);
		end
		return m;
	endfunction

endpackage

>>> rtl/prat_rule_cell.sv
// ----------------------------------------------------------------------------
// prat_rule_cell
// One table entry: rule storage, requester and peer prefix compare, and the
// stage 2 register of its fire and stop bits.
// ----------------------------------------------------------------------------
module prat_rule_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                            clk,
	input  prat_pkg::rule_wr_t              wr,
	input  logic [prat_pkg::CFG_W-1:0]      rules_in_use,
	input  logic [prat_pkg::ADDR_W-1:0]     requester_addr,
	input  logic [prat_pkg::ADDR_W-1:0]     peer_addr,
	output logic                            fire_s2,
	output logic                            stop_s2,
	output logic [prat_pkg::ADDR_W-1:0]     to_addr
);

	prat_pkg::rule_t entry_q;
	logic            in_use;
	logic            for_hit;
	logic            from_hit;

	// Entry storage, undefined until written
	always_ff @(posedge clk) begin
		if (wr.en && (32'(wr.slot) == 32'(IDX))) begin
			entry_q <= wr.rule;
		end
	end

	// Prefix compares
	assign in_use   = 32'(rules_in_use) > 32'(IDX);
	assign for_hit  = ((requester_addr ^ entry_q.for_prefix) & entry_q.for_mask) == '0;
	assign from_hit = ((peer_addr ^ entry_q.from_prefix) & entry_q.from_mask) == '0;

	// Rule ends the search: in use, requester match, and stop rule or peer match
	always_ff @(posedge clk) begin
		fire_s2 <= in_use && for_hit && (entry_q.stop || from_hit);
		stop_s2 <= entry_q.stop;
	end

	assign to_addr = entry_q.to_addr;

endmodule

>>> rtl/prat_group_sel.sv
// ----------------------------------------------------------------------------
// prat_group_sel
// Stage 2 of the lookup: finds the lowest firing rule of one group of cells
// and picks its stop flag and replacement address.
// ----------------------------------------------------------------------------
module prat_group_sel (
	input  logic                                                   clk,
	input  logic [prat_pkg::GRP_SIZE-1:0]                          fire,
	input  logic [prat_pkg::GRP_SIZE-1:0]                          stop,
	input  logic [prat_pkg::GRP_SIZE-1:0][prat_pkg::ADDR_W-1:0]    to_addr,
	output prat_pkg::grp_t                                         grp_s3
);

	prat_pkg::grp_t pick;

	// Priority pick, lowest index wins
	always_comb begin
		pick = '0;
		for (int i = prat_pkg::GRP_SIZE - 1; i >= 0; i--) begin
			if (fire[i]) begin
				pick.hit     = 1'b1;
				pick.idx     = prat_pkg::GRP_IW'(i);
				pick.stop    = stop[i];
				pick.to_addr = to_addr[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s3 <= pick;
	end

endmodule

>>> rtl/prefix_rule_address_translator_top.sv
// ----------------------------------------------------------------------------
// prefix_rule_address_translator_top
// First-match prefix rule address rewrite over a table of MAX_RULES rules.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; busy is never raised, the rule table is
// compared in parallel in stage 1 and the first hit is found by a two-level
// registered priority select (groups of 8, then across groups).
// Reset: clears stage valid bits and rules_in_use; rule entries are not reset.
// ----------------------------------------------------------------------------
module prefix_rule_address_translator_top #(
	parameter int unsigned MAX_RULES = prat_pkg::MAX_RULES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  prat_pkg::req_t                request,
	output logic                          done,
	output prat_pkg::rsp_t                result,
	input  logic                          cfg_we,
	input  logic [prat_pkg::CFG_W-1:0]    cfg_wdata
);

	localparam int unsigned NG    = (MAX_RULES + prat_pkg::GRP_SIZE - 1) / prat_pkg::GRP_SIZE;
	localparam int unsigned NCELL = NG * prat_pkg::GRP_SIZE;
	localparam int unsigned GW    = (NG > 1) ? $clog2(NG) : 1;

	logic [prat_pkg::CFG_W-1:0]                 rules_in_use_q;
	logic                                       valid_s1;
	prat_pkg::req_t                             req_s1;
	logic                                       valid_s2;
	prat_pkg::opcode_t                          opcode_s2;
	logic [prat_pkg::ADDR_W-1:0]                peer_s2;
	logic                                       valid_s3;
	prat_pkg::opcode_t                          opcode_s3;
	logic [prat_pkg::ADDR_W-1:0]                peer_s3;
	prat_pkg::rule_wr_t                         wr;
	logic [NCELL-1:0]                           fire_all;
	logic [NCELL-1:0]                           stop_all;
	logic [NCELL-1:0][prat_pkg::ADDR_W-1:0]     to_all;
	prat_pkg::grp_t                             grp_s3 [NG];
	logic                                       hit;
	logic [GW-1:0]                              hit_grp;
	prat_pkg::grp_t                             hit_sel;
	prat_pkg::rsp_t                             rsp;
	logic                                       done_q;
	prat_pkg::rsp_t                             result_q;

	// Never stalls
	assign busy = 1'b0;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_in_use_q <= '0;
		end else if (cfg_we) begin
			rules_in_use_q <= cfg_wdata;
		end
	end

	// Stage 1: input capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	// Rule write, committed as the item leaves stage 1
	always_comb begin
		wr                  = '0;
		wr.en               = valid_s1 && (req_s1.opcode == prat_pkg::OP_WRITE);
		wr.slot             = req_s1.rule_slot;
		wr.rule.for_prefix  = req_s1.new_for_prefix;
		wr.rule.for_mask    = prat_pkg::prefix_mask(req_s1.new_for_len);
		wr.rule.stop        = req_s1.new_stop;
		wr.rule.from_prefix = req_s1.new_from_prefix;
		wr.rule.from_mask   = prat_pkg::prefix_mask(req_s1.new_from_len);
		wr.rule.to_addr     = req_s1.new_to_addr;
	end

	// Rule table cells; padding up to a whole group never fires
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		if (i < MAX_RULES) begin : g_rule
			prat_rule_cell #(
				.IDX (i)
			) u_cell (
				.clk            (clk),
				.wr             (wr),
				.rules_in_use   (rules_in_use_q),
				.requester_addr (req_s1.requester_addr),
				.peer_addr      (req_s1.peer_addr),
				.fire_s2        (fire_all[i]),
				.stop_s2        (stop_all[i]),
				.to_addr        (to_all[i])
			);
		end else begin : g_pad
			assign fire_all[i] = 1'b0;
			assign stop_all[i] = 1'b0;
			assign to_all[i]   = '0;
		end
	end

	// Stage 2: per-group first hit
	for (genvar g = 0; g < NG; g++) begin : g_grp
		prat_group_sel u_grp (
			.clk     (clk),
			.fire    (fire_all[g*prat_pkg::GRP_SIZE +: prat_pkg::GRP_SIZE]),
			.stop    (stop_all[g*prat_pkg::GRP_SIZE +: prat_pkg::GRP_SIZE]),
			.to_addr (to_all[g*prat_pkg::GRP_SIZE +: prat_pkg::GRP_SIZE]),
			.grp_s3  (grp_s3[g])
		);
	end

	// Side-band of stages 2 and 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		opcode_s2 <= req_s1.opcode;
		peer_s2   <= req_s1.peer_addr;
		opcode_s3 <= opcode_s2;
		peer_s3   <= peer_s2;
	end

	// Stage 3: lowest hitting group
	always_comb begin
		hit     = 1'b0;
		hit_grp = '0;
		hit_sel = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (grp_s3[g].hit) begin
				hit     = 1'b1;
				hit_grp = GW'(g);
				hit_sel = grp_s3[g];
			end
		end
	end

	// Result formatting
	always_comb begin
		rsp             = '0;
		rsp.result_addr = peer_s3;
		if (opcode_s3 == prat_pkg::OP_WRITE) begin
			rsp = '0;
		end else if (hit) begin
			rsp.hit_valid = 1'b1;
			rsp.hit_rule  = prat_pkg::HIT_W'({hit_grp, hit_sel.idx});
			if (hit_sel.stop) begin
				rsp.stopped = 1'b1;
			end else begin
				rsp.rewritten   = 1'b1;
				rsp.result_addr = hit_sel.to_addr;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= rsp;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> rtl/prat_checker.sv
// ----------------------------------------------------------------------------
// prat_checker
// Port-level checks of the translator's item timing and result encoding.
// ----------------------------------------------------------------------------
module prat_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  prat_pkg::req_t    request,
	input  logic              done,
	input  prat_pkg::rsp_t    result
);

	// Every accepted item yields a result on done
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted item without result");

	// No result without an item accepted before it
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without accepted item");

	// Write items return an all-zero result
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(request.opcode == prat_pkg::OP_WRITE, 4) |-> result == '0)
		else $error("write item result not zero");

	// A translate without a hit returns the peer unchanged
	a_miss_peer: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.hit_valid && $past(request.opcode == prat_pkg::OP_TRANSLATE, 4)
		|-> result.result_addr == $past(request.peer_addr, 4) && result.hit_rule == '0)
		else $error("miss did not return peer address");

	// Hit flags agree: exactly one of stop or rewrite on a hit
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hit_valid == (result.rewritten || result.stopped))
			&& !(result.rewritten && result.stopped))
		else $error("inconsistent hit flags");

endmodule

bind prefix_rule_address_translator_top prat_checker u_prat_checker (.*);
